// ----- sv/tccw_pkg.sv -----
// Package for the text console character writer.
// Holds the screen geometry defaults, character codes, operation codes, controller
// states and the command and status bundles. It depends on nothing.
package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] CH_BELL   = 8'h07;
  localparam logic [7:0] CH_ERASE  = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ERRMK  = 8'h45;
  localparam logic [7:0] ATTR_RST  = 8'h0F;
  localparam int         TAB_STEP  = 4;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_EXEC,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic exec;
    logic sweep;
    logic init;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_req;
    logic sweep_done;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/text_console_char_writer.sv -----
// Top level of the text console character writer.
// Joins tccw_ctrl and tccw_datapath; depends on tccw_pkg.
//
// A COLUMNS x ROWS character-cell screen with a cursor, one 16-bit word per cell
// (attribute in the high byte, character in the low byte). Each accepted item gives
// exactly one result. An ordinary item passes from its transfer in to the next
// possible transfer in through these steps: register the item, decode it, one access
// of the single-write, single-read screen memory, load the result register once it
// is free. A result may wait in its register while the next item is already taken.
// Clear screen and any put that runs past the last cell sweep the whole memory at one
// cell per cycle through its one write port. After reset the memory is cleared by the
// same sweep, so in_ready_o stays low until that sweep is done; configuration writes
// are taken at any time.
module text_console_char_writer #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] character_i,
  input  logic [7:0] attribute_i,
  input  logic       at_cursor_i,
  input  logic [6:0] column_i,
  input  logic [4:0] row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cursor_column_o,
  output logic [4:0] cursor_row_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attribute_o,
  output logic       beep_o,
  output logic       position_error_o
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (operation_i),
    .character_i      (character_i),
    .attribute_i      (attribute_i),
    .at_cursor_i      (at_cursor_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .cell_char_o      (cell_char_o),
    .cell_attribute_o (cell_attribute_o),
    .beep_o           (beep_o),
    .position_error_o (position_error_o)
  );

endmodule

// ----- sv/tccw_ctrl.sv -----
// Controller state machine of the text console character writer.
// Sequences the reset clearing pass and each item; depends on tccw_pkg.
module tccw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tccw_pkg::sts_t  sts_i,
  output tccw_pkg::cmd_t  cmd_o
);

  tccw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tccw_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
        cmd_o.init  = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tccw_pkg::ST_CALC;
        end
      end
      tccw_pkg::ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = tccw_pkg::ST_EXEC;
      end
      tccw_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.sweep_req ? tccw_pkg::ST_SWEEP : tccw_pkg::ST_FINISH;
      end
      tccw_pkg::ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = tccw_pkg::ST_FINISH;
        end
      end
      tccw_pkg::ST_FINISH: begin
        // The result register must be empty or emptying before it is reloaded.
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = tccw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free)
    else $error("result register reloaded while still occupied");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.exec && cmd_o.sweep))
    else $error("item write and sweep write in the same cycle");

  a_sweep_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccw_pkg::ST_SWEEP && state_d != tccw_pkg::ST_SWEEP) |-> sts_i.sweep_done)
    else $error("sweep left before its last cell");

endmodule

// ----- sv/tccw_datapath.sv -----
// Datapath of the text console character writer: screen memory, cursor,
// attribute register, item decode, sweep counter and result register.
// Depends on tccw_pkg; driven by commands from tccw_ctrl.
module tccw_datapath #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tccw_pkg::cmd_t  cmd_i,
  output tccw_pkg::sts_t  sts_o,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic [1:0]      operation_i,
  input  logic [7:0]      character_i,
  input  logic [7:0]      attribute_i,
  input  logic            at_cursor_i,
  input  logic [6:0]      column_i,
  input  logic [4:0]      row_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      cursor_column_o,
  output logic [4:0]      cursor_row_o,
  output logic [7:0]      cell_char_o,
  output logic [7:0]      cell_attribute_o,
  output logic            beep_o,
  output logic            position_error_o
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SW_W   = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + tccw_pkg::TAB_STEP);
  localparam int ROW_W  = $clog2(ROWS + 1);

  // Configuration and cursor.
  logic [7:0]       def_attr_q;
  logic [COL_W-1:0] cur_col_q;
  logic [ROW_W-1:0] cur_row_q;

  // Accepted item.
  tccw_pkg::op_e    op_q;
  logic [7:0]       char_q;
  logic [7:0]       attr_q;
  logic             at_cur_q;
  logic [6:0]       col_in_q;
  logic [4:0]       row_in_q;

  // Decoded item.
  logic [COL_W-1:0] tgt_col_q, nxt_col_q;
  logic [ROW_W-1:0] tgt_row_q, nxt_row_q;
  logic             wr_q, rd_q, sweep_q, beep_q, perr_q;
  logic [15:0]      wdata_q;

  logic [COL_W-1:0] tgt_col_d, nxt_col_d, pcol, col_step;
  logic [ROW_W-1:0] tgt_row_d, nxt_row_d, prow;
  logic             wr_d, rd_d, sweep_d, beep_d, perr_d, in_range;
  logic [15:0]      wdata_d;
  logic [7:0]       eff_attr;

  // Memory and sweep.
  logic [15:0]       screen_q [CELLS];
  logic [15:0]       rdata_q;
  logic [SW_W-1:0]   sw_q;
  logic              mem_we, mem_re, scroll_mode, sweep_done;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr, item_addr;
  logic [15:0]       mem_wdata, fill_word;

  // Result register.
  logic             out_valid_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic [15:0]      out_cell_q;
  logic             out_beep_q, out_perr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= tccw_pkg::OP_PUT;
    end else if (cmd_i.load) begin
      op_q <= tccw_pkg::op_e'(operation_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q   <= character_i;
      attr_q   <= attribute_i;
      at_cur_q <= at_cursor_i;
      col_in_q <= column_i;
      row_in_q <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= tccw_pkg::ATTR_RST;
    end else if (cfg_we_i) begin
      def_attr_q <= cfg_wdata_i;
    end
  end

  // Item decode: target cell, memory action and the cursor after the item.
  always_comb begin
    in_range  = at_cur_q || ((32'(col_in_q) < 32'(COLUMNS)) && (32'(row_in_q) < 32'(ROWS)));
    pcol      = at_cur_q ? cur_col_q : COL_W'(col_in_q);
    prow      = at_cur_q ? cur_row_q : ROW_W'(row_in_q);
    eff_attr  = (attr_q == 8'd0) ? def_attr_q : attr_q;
    tgt_col_d = pcol;
    tgt_row_d = prow;
    nxt_col_d = cur_col_q;
    nxt_row_d = cur_row_q;
    wr_d      = 1'b0;
    rd_d      = 1'b0;
    sweep_d   = 1'b0;
    beep_d    = 1'b0;
    perr_d    = 1'b0;
    wdata_d   = {eff_attr, char_q};
    col_step  = '0;
    unique case (op_q)
      tccw_pkg::OP_PUT: begin
        if (!in_range) begin
          tgt_col_d = COL_W'(COLUMNS - 1);
          tgt_row_d = ROW_W'(ROWS - 1);
          wr_d      = 1'b1;
          wdata_d   = {def_attr_q, tccw_pkg::CH_ERRMK};
          perr_d    = 1'b1;
        end else begin
          nxt_col_d = pcol;
          nxt_row_d = prow;
          priority if (char_q == tccw_pkg::CH_TAB) begin
            col_step = pcol + COL_W'(tccw_pkg::TAB_STEP);
          end else if (char_q == tccw_pkg::CH_BELL) begin
            beep_d   = 1'b1;
            col_step = pcol;
          end else if (char_q == tccw_pkg::CH_NL) begin
            col_step = COL_W'(COLUMNS);
          end else if (char_q == tccw_pkg::CH_ERASE) begin
            wr_d     = 1'b1;
            wdata_d  = {eff_attr, tccw_pkg::CH_SPACE};
            col_step = pcol;
          end else begin
            wr_d     = 1'b1;
            col_step = pcol + COL_W'(1);
          end
          // A step past the row end wraps once: the step never exceeds one row.
          if (col_step >= COL_W'(COLUMNS)) begin
            nxt_col_d = col_step - COL_W'(COLUMNS);
            nxt_row_d = prow + ROW_W'(1);
          end else begin
            nxt_col_d = col_step;
          end
          if (nxt_row_d == ROW_W'(ROWS)) begin
            sweep_d   = 1'b1;
            nxt_row_d = ROW_W'(ROWS - 1);
          end
        end
      end
      tccw_pkg::OP_BACKSPACE: begin
        if (cur_col_q != '0) begin
          nxt_col_d = cur_col_q - COL_W'(1);
        end else if (cur_row_q != '0) begin
          nxt_col_d = COL_W'(COLUMNS - 1);
          nxt_row_d = cur_row_q - ROW_W'(1);
        end
        tgt_col_d = nxt_col_d;
        tgt_row_d = nxt_row_d;
        wr_d      = 1'b1;
        wdata_d   = {def_attr_q, tccw_pkg::CH_SPACE};
      end
      tccw_pkg::OP_CLEAR: begin
        nxt_col_d = '0;
        nxt_row_d = '0;
        sweep_d   = 1'b1;
      end
      tccw_pkg::OP_READ: begin
        if (!in_range) begin
          perr_d = 1'b1;
        end else begin
          rd_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      tgt_col_q <= tgt_col_d;
      tgt_row_q <= tgt_row_d;
      nxt_col_q <= nxt_col_d;
      nxt_row_q <= nxt_row_d;
      wdata_q   <= wdata_d;
      beep_q    <= beep_d;
      perr_q    <= perr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      sweep_q <= 1'b0;
    end else if (cmd_i.calc) begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      sweep_q <= sweep_d;
    end
  end

  // Sweep: counter value k writes cell k-1 and, when scrolling, reads the cell
  // one row below cell k, so each copied word arrives in the cycle after its read.
  assign item_addr   = ADDR_W'(tgt_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(tgt_col_q);
  assign sweep_done  = (sw_q == SW_W'(CELLS));
  assign scroll_mode = !cmd_i.init && (op_q != tccw_pkg::OP_CLEAR);

  always_comb begin
    priority if (cmd_i.init || op_q != tccw_pkg::OP_CLEAR) begin
      fill_word = '0;
    end else begin
      fill_word = {def_attr_q, tccw_pkg::CH_SPACE};
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_addr;
    mem_wdata = wdata_q;
    mem_re    = 1'b0;
    mem_raddr = item_addr;
    if (cmd_i.exec) begin
      mem_we = wr_q;
      mem_re = rd_q;
    end else if (cmd_i.sweep) begin
      mem_we    = (sw_q != '0);
      mem_waddr = ADDR_W'(sw_q - SW_W'(1));
      if (scroll_mode && (sw_q <= SW_W'(CELLS - COLUMNS))) begin
        mem_wdata = rdata_q;
      end else begin
        mem_wdata = fill_word;
      end
      mem_re    = scroll_mode && (sw_q < SW_W'(CELLS - COLUMNS));
      mem_raddr = ADDR_W'(sw_q) + ADDR_W'(COLUMNS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else if (cmd_i.exec) begin
      sw_q <= '0;
    end else if (cmd_i.sweep && !sweep_done) begin
      sw_q <= sw_q + SW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        cur_col_q   <= nxt_col_q;
        cur_row_q   <= nxt_row_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_col_q  <= nxt_col_q;
      out_row_q  <= nxt_row_q;
      out_cell_q <= rd_q ? rdata_q : 16'd0;
      out_beep_q <= beep_q;
      out_perr_q <= perr_q;
    end
  end

  assign sts_o.sweep_req  = sweep_q;
  assign sts_o.sweep_done = sweep_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign cursor_column_o  = 7'(out_col_q);
  assign cursor_row_o     = 5'(out_row_q);
  assign cell_char_o      = out_cell_q[7:0];
  assign cell_attribute_o = out_cell_q[15:8];
  assign beep_o           = out_beep_q;
  assign position_error_o = out_perr_q;

  a_cursor_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q < COL_W'(COLUMNS)) && (cur_row_q < ROW_W'(ROWS)))
    else $error("cursor left the screen");

  a_sweep_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && sweep_q) |=> (sw_q == '0))
    else $error("sweep did not start from the first cell");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_beep_q && out_perr_q))
    else $error("beep and position error in one result");

endmodule
